// ===== sv/cbt_pkg.sv =====
// Package for the cubic Bezier tessellator: shared types and constants.
// Used by cbt_ctrl, cbt_dp and cubic_bezier_tessellator; depends on nothing.
package cbt_pkg;

    localparam int CoordW = 32;
    localparam int StepW  = 5;
    localparam int UW     = 17;   // u in Q1.16, 0..65536
    localparam int WW     = 18;   // rounded weight, 0..65536 plus headroom

    localparam logic [StepW-1:0] StepReset = 5'd20;
    localparam logic [StepW-1:0] StepMax   = 5'd30;

    typedef enum logic [1:0] {
        ADDR_STEP   = 2'd0,
        ADDR_CLOSED = 2'd1
    } t_reg_addr;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEG,
        ST_WRAP,
        ST_FIRST,
        ST_WAIT
    } t_state;

    typedef struct packed {
        logic       load;      // capture input handle
        logic       seg_a_cur; // segment start is the current handle, else previous
        logic       seg_b_first; // loaded handle is the first of a curve and is kept for the wrap
        logic       issue;     // push sample t into the datapath
        logic       issue_pt;  // push the first anchor point as a vertex
        logic       issue_last;
        logic [StepW-1:0] t;
    } t_dp_cmd;

    typedef struct packed {
        logic busy;   // samples still in flight or waiting at the output
        logic space;  // pipeline may take a new sample
    } t_dp_sts;

endpackage

// ===== sv/cbt_dp.sv =====
// Datapath: handle registers, u/weight pipeline, weighted sum and rounding.
// Depends on cbt_pkg; driven by cbt_ctrl.
module cbt_dp import cbt_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_dp_cmd                  i_cmd,
    input  logic [StepW-1:0]         i_n,
    input  logic signed [CoordW-1:0] i_hx [6],
    output t_dp_sts                  o_sts,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [CoordW-1:0]        o_x,
    output logic [CoordW-1:0]        o_y,
    output logic                     o_last
);
    localparam int NS = 5;
    logic signed [CoordW-1:0] r_cur [6];
    logic signed [CoordW-1:0] r_prev [6];
    logic signed [CoordW-1:0] r_first [6];

    // Stage 0: pick the segment control points and u.
    logic [NS-1:0] r_v;
    logic r_lst [NS];
    logic signed [CoordW:0] r_c0 [2], r_c1 [2], r_c2 [2], r_c3 [2];
    logic signed [CoordW:0] r1_c0 [2], r1_c1 [2], r1_c2 [2], r1_c3 [2];
    logic signed [CoordW:0] r2_c0 [2], r2_c1 [2], r2_c2 [2], r2_c3 [2];
    logic [UW-1:0] r_u, r_mu;
    logic [2*UW-1:0] r_uu, r_mm, r_um;
    logic [UW-1:0] r1_u, r1_mu;
    logic [WW-1:0] r_w0, r_w1, r_w2, r_w3;
    logic signed [CoordW+WW:0] r_p [2][4];
    logic signed [CoordW+WW+3:0] r_acc [2];
    logic [CoordW-1:0] r_ox, r_oy;
    logic r_ov, r_ol;
    logic adv;
    logic [26:0] recip_tab [32];
    logic [20:0] u_num;
    logic [47:0] u_prod;
    logic [UW-1:0] u_calc, u_sel;

    // u = (t*65536 + n/2) / n by multiplying with ceil(2^26/n). The numerator
    // stays below 2^21 and the reciprocal error below n, so the quotient is exact.
    for (genvar g = 0; g < 32; g++) begin : g_recip
        localparam int Den = (g == 0) ? 1 : g;
        localparam logic [26:0] Recip = 27'((67108864 + Den - 1) / Den);
        assign recip_tab[g] = Recip;
    end

    assign u_num  = {i_cmd.t, 16'd0} + 21'(i_n[StepW-1:1]);
    assign u_prod = 48'(u_num) * 48'(recip_tab[i_n]);
    assign u_calc = u_prod[26 +: UW];
    assign u_sel  = i_cmd.issue_pt ? UW'(65536) : u_calc;

    function automatic logic signed [CoordW-1:0] f_sat(
        input logic signed [CoordW+WW+3:0] a);
        logic signed [CoordW+WW+3:0] r, hi, lo;
        begin
            r  = (a + 32768) >>> 16;
            hi = (CoordW+WW+4)'((64'sd1 <<< (COORD_WIDTH-1)) - 1);
            lo = -(CoordW+WW+4)'(64'sd1 <<< (COORD_WIDTH-1));
            if (r > hi) r = hi;
            if (r < lo) r = lo;
            return r[CoordW-1:0];
        end
    endfunction

    assign adv = !r_ov || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
            r_ov <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_cur[i] <= '0;
                r_prev[i] <= '0;
                r_first[i] <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                for (int i = 0; i < 6; i++) begin
                    r_prev[i] <= r_cur[i];
                    r_cur[i] <= i_hx[i];
                end
                // The first handle of a curve is kept for the closing segment.
                if (i_cmd.seg_b_first)
                    for (int i = 0; i < 6; i++) r_first[i] <= i_hx[i];
            end
            if (adv) begin
                r_v <= {r_v[NS-2:0], i_cmd.issue | i_cmd.issue_pt};
                r_ov <= r_v[NS-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_lst[0] <= i_cmd.issue_last;
            for (int k = 1; k < NS; k++) begin
                r_lst[k] <= r_lst[k-1];
            end
            for (int d = 0; d < 2; d++) begin
                if (i_cmd.issue_pt) begin
                    r_c0[d] <= '0; r_c1[d] <= '0; r_c2[d] <= '0;
                    r_c3[d] <= {r_first[d][CoordW-1], r_first[d]};
                end else if (i_cmd.seg_a_cur) begin
                    r_c0[d] <= {r_cur[d][CoordW-1], r_cur[d]};
                    r_c1[d] <= {r_cur[d][CoordW-1], r_cur[d]}
                             + {r_cur[4+d][CoordW-1], r_cur[4+d]};
                    r_c2[d] <= {r_first[d][CoordW-1], r_first[d]}
                             + {r_first[2+d][CoordW-1], r_first[2+d]};
                    r_c3[d] <= {r_first[d][CoordW-1], r_first[d]};
                end else begin
                    r_c0[d] <= {r_prev[d][CoordW-1], r_prev[d]};
                    r_c1[d] <= {r_prev[d][CoordW-1], r_prev[d]}
                             + {r_prev[4+d][CoordW-1], r_prev[4+d]};
                    r_c2[d] <= {r_cur[d][CoordW-1], r_cur[d]}
                             + {r_cur[2+d][CoordW-1], r_cur[2+d]};
                    r_c3[d] <= {r_cur[d][CoordW-1], r_cur[d]};
                end
                r1_c0[d] <= r_c0[d]; r1_c1[d] <= r_c1[d];
                r1_c2[d] <= r_c2[d]; r1_c3[d] <= r_c3[d];
                r2_c0[d] <= r1_c0[d]; r2_c1[d] <= r1_c1[d];
                r2_c2[d] <= r1_c2[d]; r2_c3[d] <= r1_c3[d];
            end
            r_u  <= u_sel;
            r_mu <= UW'(65536) - u_sel;
            // stage 1: squares
            r_uu <= r_u * r_u;
            r_mm <= r_mu * r_mu;
            r_um <= r_u * r_mu;
            r1_u <= r_u;
            r1_mu <= r_mu;
            // stage 2: cubes rounded to Q.16
            r_w0 <= WW'((51'(r_mm) * r1_mu + 51'h80000000) >> 32);
            r_w1 <= WW'((51'(r_mm) * r1_u * 3 + 53'h80000000) >> 32);
            r_w2 <= WW'((51'(r_uu) * r1_mu * 3 + 53'h80000000) >> 32);
            r_w3 <= WW'((51'(r_uu) * r1_u + 51'h80000000) >> 32);
            // stage 3: products
            for (int d = 0; d < 2; d++) begin
                r_p[d][0] <= $signed({1'b0, r_w0}) * r2_c0[d];
                r_p[d][1] <= $signed({1'b0, r_w1}) * r2_c1[d];
                r_p[d][2] <= $signed({1'b0, r_w2}) * r2_c2[d];
                r_p[d][3] <= $signed({1'b0, r_w3}) * r2_c3[d];
                // stage 4: sum
                r_acc[d] <= (CoordW+WW+4)'(r_p[d][0]) + (CoordW+WW+4)'(r_p[d][1])
                          + (CoordW+WW+4)'(r_p[d][2]) + (CoordW+WW+4)'(r_p[d][3]);
            end
            // stage 5: round, saturate
            r_ox <= f_sat(r_acc[0]);
            r_oy <= f_sat(r_acc[1]);
            r_ol <= r_lst[NS-1];
        end
    end

    assign o_valid = r_ov;
    assign o_x = r_ox;
    assign o_y = r_oy;
    assign o_last = r_ol;
    assign o_sts.busy = |r_v || r_ov;
    assign o_sts.space = adv;
endmodule

// ===== sv/cbt_ctrl.sv =====
// Controller state machine: sequences sample issue per segment and wrap.
// Depends on cbt_pkg; commands cbt_dp.
module cbt_ctrl import cbt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last,
    input  logic             i_closed,
    input  logic [StepW-1:0] i_n,
    input  t_dp_sts          i_sts,
    output logic             o_in_ready,
    output t_dp_cmd          o_cmd
);
    t_state r_st, n_st;
    logic [StepW-1:0] r_t, n_t;
    logic r_have, n_have, r_last, n_last, r_cl, n_cl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_t <= '0; r_have <= 1'b0;
            r_last <= 1'b0; r_cl <= 1'b0;
        end else begin
            r_st <= n_st; r_t <= n_t; r_have <= n_have;
            r_last <= n_last; r_cl <= n_cl;
        end
    end

    always_comb begin
        n_st = r_st; n_t = r_t; n_have = r_have; n_last = r_last; n_cl = r_cl;
        case (r_st)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_t = '0; n_last = i_last; n_cl = i_closed;
                    n_have = !i_last;
                    if (r_have) n_st = ST_SEG;
                    else if (i_last && i_closed) n_st = ST_WRAP;
                end
            end
            ST_SEG: if (i_sts.space) begin
                if (r_t == i_n) begin
                    n_t = '0;
                    n_st = (r_last && r_cl) ? ST_WRAP : ST_WAIT;
                end else n_t = r_t + 1'b1;
            end
            ST_WRAP: if (i_sts.space) begin
                if (r_t == i_n) n_st = ST_FIRST;
                else n_t = r_t + 1'b1;
            end
            ST_FIRST: if (i_sts.space) n_st = ST_WAIT;
            ST_WAIT: if (!i_sts.busy) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_st == ST_IDLE) && !i_sts.busy;
        o_cmd = '0;
        o_cmd.t = r_t;
        case (r_st)
            ST_IDLE: begin
                o_cmd.load = i_in_valid && !i_sts.busy;
                o_cmd.seg_b_first = !r_have;
            end
            ST_SEG: begin
                o_cmd.issue = i_sts.space;
                o_cmd.issue_last = (r_t == i_n) && !(r_last && r_cl);
            end
            ST_WRAP: begin
                o_cmd.issue = i_sts.space;
                o_cmd.seg_a_cur = 1'b1;
            end
            ST_FIRST: begin
                o_cmd.issue_pt = i_sts.space;
                o_cmd.issue_last = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

// ===== sv/cubic_bezier_tessellator.sv =====
// Top level of the cubic Bezier tessellator: ports, register file, assertions.
// Depends on cbt_pkg, cbt_ctrl and cbt_dp.
//
// Each accepted handle item closes the cubic segment begun by the previous
// handle of the same curve and produces n+1 vertex items (n being step_count
// clamped to 1..30), one per cycle while the output is not stalled, through
// a six-stage arithmetic pipeline (u, squares, cubic weights, products, sum,
// round and saturate). The first handle of a curve produces none. In closed
// mode the handle marked tlast also produces the wrapping segment back to
// the first handle and then the first anchor point. A handle therefore
// issues n+1 samples (2n+3 when a later handle closes the curve, n+2 for a
// lone closed handle), and the next handle is taken only once the pipeline
// has drained and the last vertex has left: the controller works on one
// handle at a time. A vertex waiting in the output register stalls the
// pipeline without losing data. Registers: step_count at byte 0,
// closed_loop at byte 4; write them only while the block is idle.
module cubic_bezier_tessellator import cbt_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // point_x, point_y, left_dx, left_dy, right_dx, right_dy (low bits first)
    input  logic [191:0] s_axis_tdata,
    input  logic         s_axis_tlast,   // end_of_curve
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // vertex_x, vertex_y (low bits first)
    output logic [63:0]  m_axis_tdata,
    output logic         m_axis_tlast,   // run_last
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [StepW-1:0] r_step;
    logic             r_closed;
    logic [StepW-1:0] n_eff;
    logic signed [CoordW-1:0] hx [6];
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= StepReset;
            r_closed <= 1'b0;
        end else if (wr) begin
            if (paddr[2] == ADDR_STEP[0] && paddr[1:0] == 2'b00) r_step <= pwdata[StepW-1:0];
            if (paddr[2] == ADDR_CLOSED[0] && paddr[1:0] == 2'b00) r_closed <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == ADDR_STEP[0]) prdata = 32'(r_step);
        else prdata = 32'(r_closed);
    end

    // Zero steps count as one; above thirty saturate.
    assign n_eff = (r_step == '0) ? StepW'(1) : (r_step > StepMax ? StepMax : r_step);

    always_comb
        for (int i = 0; i < 6; i++) hx[i] = s_axis_tdata[i*32 +: 32];

    cbt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .i_last(s_axis_tlast), .i_closed(r_closed), .i_n(n_eff),
        .i_sts(sts), .o_in_ready(s_axis_tready), .o_cmd(cmd)
    );

    cbt_dp #(.COORD_WIDTH(COORD_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_n(n_eff), .i_hx(hx),
        .o_sts(sts), .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_x(m_axis_tdata[31:0]), .o_y(m_axis_tdata[63:32]), .o_last(m_axis_tlast)
    );

    // A held output vertex must not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output vertex changed under stall");
    // No new handle is taken while a vertex is still waiting at the output.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("handle accepted with vertices pending");
endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for cubic_bezier_tessellator: stream and register stimulus,
// an in-bench vertex predictor and an in-order result checker.
// Depends on cbt_pkg and the RTL of the tessellator only.
module tb;
    import cbt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MaxSteps = 30;
    localparam int DrainCycles = 16;

    typedef struct {
        logic signed [31:0] px, py, lx, ly, rx, ry;
    } t_handle;

    typedef struct {
        logic [31:0] x, y;
        logic        last;
    } t_vertex;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // point_x, point_y, left_dx, left_dy, right_dx, right_dy (low bits first)
    logic [191:0] s_axis_tdata;
    logic         s_axis_tlast;   // end_of_curve
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // vertex_x, vertex_y (low bits first)
    logic [63:0]  m_axis_tdata;
    logic         m_axis_tlast;   // run_last
    logic         psel, penable, pwrite;
    logic [2:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    cubic_bezier_tessellator uut (.*);

    // Predictor state, mirroring the block's registers and handle store.
    t_handle     prev_handle, first_handle;
    bit          have_prev;
    logic [4:0]  step_reg;
    bit          closed_reg;

    t_vertex     vertex_q[$];
    int          error_count;
    bit          no_idle;      // when set, neither side idles at random
    int          hold_cycles;  // receiver holds off for this many cycles

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // The run is ended here if the block ever hangs.
    initial begin
        #20ms;
        $display("FAILURE");
        $finish;
    end

    // Receiver: tready changes once per falling edge, either from a long
    // hold-off, a stretch with no idling, or a random idle of about a third.
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            m_axis_tready <= 1'b0;
            hold_cycles   <= hold_cycles - 1;
        end else if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= 34);
        end
    end

    // Checker: every accepted vertex item is compared with the oldest one expected.
    always @(posedge i_clk) begin
        t_vertex exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (vertex_q.size() == 0) begin
                $display("%0t: unexpected vertex x=%h y=%h last=%b", $realtime,
                         m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tlast);
                error_count++;
            end else begin
                exp_v = vertex_q.pop_front();
                if (m_axis_tdata[31:0] !== exp_v.x) begin
                    $display("%0t: vertex_x expected %h actual %h", $realtime,
                             exp_v.x, m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[63:32] !== exp_v.y) begin
                    $display("%0t: vertex_y expected %h actual %h", $realtime,
                             exp_v.y, m_axis_tdata[63:32]);
                    error_count++;
                end
                if (m_axis_tlast !== exp_v.last) begin
                    $display("%0t: run_last expected %b actual %b", $realtime,
                             exp_v.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // Round a Q.32 accumulator to Q.16 (halves up) and saturate to 32 bits.
    function automatic logic [31:0] round_sat(longint signed acc);
        longint signed v;
        v = (acc + 64'sd32768) >>> 16;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    function automatic void push_vertex(logic [31:0] x, logic [31:0] y);
        t_vertex v;
        v.x = x;
        v.y = y;
        v.last = 1'b0;
        vertex_q = {vertex_q, v};
    endfunction

    // Samples the cubic from handle a to handle b at n+1 evenly spaced parameters.
    function automatic void tessellate_segment(t_handle a, t_handle b, int n);
        longint signed   cx[4], cy[4], w[4], ax, ay;
        longint unsigned u, mu;
        cx[0] = a.px;
        cy[0] = a.py;
        cx[1] = longint'(a.px) + longint'(a.rx);
        cy[1] = longint'(a.py) + longint'(a.ry);
        cx[2] = longint'(b.px) + longint'(b.lx);
        cy[2] = longint'(b.py) + longint'(b.ly);
        cx[3] = b.px;
        cy[3] = b.py;
        for (int t = 0; t <= n; t++) begin
            u  = (longint'(t) * 65536 + n / 2) / n;
            mu = 65536 - u;
            w[0] = (mu * mu * mu + 64'h8000_0000) >> 32;
            w[1] = (3 * mu * mu * u + 64'h8000_0000) >> 32;
            w[2] = (3 * mu * u * u + 64'h8000_0000) >> 32;
            w[3] = (u * u * u + 64'h8000_0000) >> 32;
            ax = 0;
            ay = 0;
            for (int i = 0; i < 4; i++) begin
                ax += w[i] * cx[i];
                ay += w[i] * cy[i];
            end
            push_vertex(round_sat(ax), round_sat(ay));
        end
    endfunction

    // Works out every vertex one accepted handle item produces.
    function automatic void predict_handle(t_handle h, bit end_curve);
        int n;
        int before_size;
        before_size = vertex_q.size();
        n = (step_reg == 0) ? 1 : (step_reg > MaxSteps) ? MaxSteps : int'(step_reg);
        if (have_prev)
            tessellate_segment(prev_handle, h, n);
        else
            first_handle = h;
        if (end_curve && closed_reg) begin
            tessellate_segment(h, first_handle, n);
            push_vertex(first_handle.px, first_handle.py);
        end
        prev_handle = h;
        have_prev = !end_curve;
        if (vertex_q.size() > before_size)
            vertex_q[$].last = 1'b1;
    endfunction

    // Sends one handle item; tvalid is set once per falling edge and is not
    // lowered after acceptance, so back-to-back items keep it high.
    task automatic send_handle(t_handle h, bit end_curve);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {h.ry, h.rx, h.ly, h.lx, h.py, h.px};
        s_axis_tlast  <= end_curve;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_handle(h, end_curve);
    endtask

    task automatic sender_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits until every expected vertex has come and the pipeline has drained.
    task automatic wait_idle();
        sender_idle();
        while (vertex_q.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle; the block is idle here.
    task automatic write_reg(t_reg_addr idx, logic [31:0] value);
        wait_idle();
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx[0], 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == ADDR_STEP) step_reg = value[4:0];
        else closed_reg = value[0];
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom_range(32'h0020_0000) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_handle rand_handle();
        t_handle h;
        h.px = rand_coord();
        h.py = rand_coord();
        h.lx = rand_coord();
        h.ly = rand_coord();
        h.rx = rand_coord();
        h.ry = rand_coord();
        return h;
    endfunction

    function automatic t_handle all_fields(logic [31:0] v);
        t_handle h;
        h = '{v, v, v, v, v, v};
        return h;
    endfunction

    // Sends one curve of the given length with random content.
    task automatic send_curve(int len);
        for (int i = 0; i < len; i++)
            send_handle(rand_handle(), i == len - 1);
    endtask

    // Extremes of every field, open and closed curves and the single-handle cases.
    task automatic test_directed();
        write_reg(ADDR_STEP, 32'd3);
        send_handle(all_fields(32'h7FFF_FFFF), 1'b0);
        send_handle(all_fields(32'h8000_0000), 1'b0);
        send_handle(all_fields(32'h0), 1'b1);
        // A lone handle in open mode produces nothing at all.
        send_handle(rand_handle(), 1'b1);
        write_reg(ADDR_CLOSED, 32'd1);
        // A lone handle in closed mode wraps onto itself.
        send_handle(all_fields(32'h8000_0000), 1'b1);
        send_handle(all_fields(32'h7FFF_FFFF), 1'b0);
        send_handle(all_fields(32'h8000_0000), 1'b0);
        send_handle(all_fields(32'h0001_0000), 1'b1);
        // A step count of zero behaves as one; above the maximum it saturates.
        write_reg(ADDR_STEP, 32'd0);
        send_curve(3);
        write_reg(ADDR_STEP, 32'd31);
        send_curve(2);
        write_reg(ADDR_STEP, 32'd30);
        send_curve(2);
        write_reg(ADDR_CLOSED, 32'd0);
        write_reg(ADDR_STEP, 32'd1);
        send_curve(4);
        // A register change in the middle of a curve applies from the next item.
        send_handle(rand_handle(), 1'b0);
        write_reg(ADDR_STEP, 32'd2);
        send_handle(rand_handle(), 1'b1);
    endtask

    // Mostly well-formed curves with random content over several settings.
    task automatic test_random();
        int sent;
        int len;
        sent = 0;
        while (sent < 130) begin
            if ($urandom_range(9) == 0) begin
                write_reg(ADDR_STEP, ($urandom_range(9) == 0) ? $urandom_range(31)
                                                               : $urandom_range(1, 6));
                write_reg(ADDR_CLOSED, $urandom_range(1));
            end
            if (sent > 40 && sent < 70) no_idle = 1'b1;
            else no_idle = 1'b0;
            if ($urandom_range(9) < 8) begin
                len = $urandom_range(1, 6);
                send_curve(len);
                sent += len;
            end else begin
                // Noise: an item with a random end marker.
                send_handle(rand_handle(), $urandom_range(1));
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    // The receiver holds off for long while items keep being offered.
    task automatic test_backpressure();
        write_reg(ADDR_STEP, 32'd4);
        write_reg(ADDR_CLOSED, 32'd1);
        hold_cycles = 400;
        send_curve(3);
        send_curve(2);
    endtask

    // The sender pauses mid-curve until every expected vertex has arrived.
    task automatic test_sender_pause();
        send_handle(rand_handle(), 1'b0);
        send_handle(rand_handle(), 1'b0);
        wait_idle();
        send_handle(rand_handle(), 1'b1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        error_count   = 0;
        no_idle       = 1'b0;
        hold_cycles   = 0;
        have_prev     = 1'b0;
        prev_handle   = all_fields(32'h0);
        first_handle  = all_fields(32'h0);
        step_reg      = StepReset;
        closed_reg    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_sender_pause();
        test_random();

        wait_idle();
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
sv/cbt_pkg.sv
sv/cbt_dp.sv
sv/cbt_ctrl.sv
sv/cubic_bezier_tessellator.sv
verif/tb.sv
